// File: rtl/hkc_pkg.sv
// Shared types, codes and constants of the Hangul keystroke composer.
package hkc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic [4:0] idx_t;
  localparam idx_t IDX_NONE = 5'd31;

  localparam idx_t NUM_INITIALS = 5'd19;
  localparam idx_t NUM_MEDIALS  = 5'd21;
  localparam idx_t LAST_FINAL   = 5'd27;

  localparam logic [15:0] SYLLABLE_BASE       = 16'hAC00;
  localparam logic [15:0] INITIAL_STRIDE      = 16'd588;
  localparam logic [15:0] MEDIAL_STRIDE       = 16'd28;
  localparam logic [15:0] CONSONANT_JAMO_BASE = 16'h3131;
  localparam logic [15:0] VOWEL_JAMO_BASE     = 16'h314F;

  typedef enum logic [1:0] {
    OP_TYPE      = 2'd0,
    OP_BACKSPACE = 2'd1,
    OP_FLUSH     = 2'd2
  } op_e;

  typedef enum logic {
    KIND_CHAR  = 1'b0,
    KIND_ERASE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] key;
    idx_t       ic;
    idx_t       im;
    idx_t       jf;
  } cls_item_t;

endpackage

// File: rtl/hkc_if.sv
// Handshake channel interfaces for keystrokes in and characters out.
interface hkc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink (input valid, input operation, input key, output ready);
endinterface

interface hkc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] code_point;
  logic        last;

  modport source (output valid, output kind, output code_point, output last, input ready);
  modport sink (input valid, input kind, input code_point, input last, output ready);
endinterface

// File: rtl/hkc_front.sv
// Front end: accepts keystroke items and classifies keys into jamo indices.
module hkc_front
  import hkc_pkg::*;
(
  hkc_in_if.sink    in_i,
  input  logic      q_ready_i,
  output logic      push_o,
  output cls_item_t item_o
);

  function automatic idx_t initial_of(input logic [7:0] k);
    idx_t r;
    r = IDX_NONE;
    case (k)
      "r": r = 5'd0;
      "R": r = 5'd1;
      "s": r = 5'd2;
      "e": r = 5'd3;
      "E": r = 5'd4;
      "f": r = 5'd5;
      "a": r = 5'd6;
      "q": r = 5'd7;
      "Q": r = 5'd8;
      "t": r = 5'd9;
      "T": r = 5'd10;
      "d": r = 5'd11;
      "w": r = 5'd12;
      "W": r = 5'd13;
      "c": r = 5'd14;
      "z": r = 5'd15;
      "x": r = 5'd16;
      "v": r = 5'd17;
      "g": r = 5'd18;
      default: r = IDX_NONE;
    endcase
    return r;
  endfunction

  function automatic idx_t medial_of(input logic [7:0] k);
    idx_t r;
    r = IDX_NONE;
    case (k)
      "k": r = 5'd0;
      "o": r = 5'd1;
      "i": r = 5'd2;
      "O": r = 5'd3;
      "j": r = 5'd4;
      "p": r = 5'd5;
      "u": r = 5'd6;
      "P": r = 5'd7;
      "h": r = 5'd8;
      "y": r = 5'd12;
      "n": r = 5'd13;
      "b": r = 5'd17;
      "m": r = 5'd18;
      "l": r = 5'd20;
      default: r = IDX_NONE;
    endcase
    return r;
  endfunction

  function automatic idx_t final_of(input logic [7:0] k);
    idx_t r;
    r = IDX_NONE;
    case (k)
      "r": r = 5'd1;
      "R": r = 5'd2;
      "s": r = 5'd4;
      "e": r = 5'd7;
      "f": r = 5'd8;
      "a": r = 5'd16;
      "q": r = 5'd17;
      "t": r = 5'd19;
      "T": r = 5'd20;
      "d": r = 5'd21;
      "w": r = 5'd22;
      "c": r = 5'd23;
      "z": r = 5'd24;
      "x": r = 5'd25;
      "v": r = 5'd26;
      "g": r = 5'd27;
      default: r = IDX_NONE;
    endcase
    return r;
  endfunction

  assign in_i.ready = q_ready_i;
  assign push_o     = in_i.valid & q_ready_i;

  always_comb begin
    item_o.op  = in_i.operation;
    item_o.key = in_i.key;
    item_o.ic  = initial_of(in_i.key);
    item_o.im  = medial_of(in_i.key);
    item_o.jf  = final_of(in_i.key);
  end

endmodule

// File: rtl/hkc_queue.sv
// Short queue of classified items between the front and back ends.
module hkc_queue
  import hkc_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cls_item_t item_i,
  output logic      ready_o,
  input  logic      pop_i,
  output logic      valid_o,
  output cls_item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cls_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntFull);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/hkc_back.sv
// Back end: composition state, commit logic and registered result output.
module hkc_back
  import hkc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cls_item_t  q_item_i,
  output logic       pop_o,
  hkc_out_if.source  res_o
);

  function automatic idx_t combine_medial(input idx_t a, input idx_t b);
    idx_t r;
    r = IDX_NONE;
    if (a == 5'd8) begin
      if (b == 5'd0) r = 5'd9;
      else if (b == 5'd1) r = 5'd10;
      else if (b == 5'd20) r = 5'd11;
    end else if (a == 5'd13) begin
      if (b == 5'd4) r = 5'd14;
      else if (b == 5'd5) r = 5'd15;
      else if (b == 5'd20) r = 5'd16;
    end else if (a == 5'd18 && b == 5'd20) begin
      r = 5'd19;
    end
    return r;
  endfunction

  function automatic idx_t combine_final(input idx_t a, input idx_t b);
    idx_t r;
    r = IDX_NONE;
    if (a == 5'd1 && b == 5'd19) r = 5'd3;
    else if (a == 5'd4) begin
      if (b == 5'd22) r = 5'd5;
      else if (b == 5'd27) r = 5'd6;
    end else if (a == 5'd8) begin
      case (b)
        5'd1:    r = 5'd9;
        5'd16:   r = 5'd10;
        5'd17:   r = 5'd11;
        5'd19:   r = 5'd12;
        5'd25:   r = 5'd13;
        5'd26:   r = 5'd14;
        5'd27:   r = 5'd15;
        default: r = IDX_NONE;
      endcase
    end else if (a == 5'd17 && b == 5'd19) begin
      r = 5'd18;
    end
    return r;
  endfunction

  function automatic idx_t final_keep(input idx_t f);
    idx_t r;
    case (f)
      5'd3:                                   r = 5'd1;
      5'd5, 5'd6:                             r = 5'd4;
      5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15: r = 5'd8;
      5'd18:                                  r = 5'd17;
      default:                                r = IDX_NONE;
    endcase
    return r;
  endfunction

  function automatic idx_t final_moved(input idx_t f);
    idx_t r;
    case (f)
      5'd3, 5'd12, 5'd18: r = 5'd19;
      5'd5:               r = 5'd22;
      5'd6, 5'd15:        r = 5'd27;
      5'd9:               r = 5'd1;
      5'd10:              r = 5'd16;
      5'd11:              r = 5'd17;
      5'd13:              r = 5'd25;
      5'd14:              r = 5'd26;
      default:            r = f;
    endcase
    return r;
  endfunction

  function automatic idx_t final_to_initial(input idx_t f);
    idx_t r;
    case (f)
      5'd1:    r = 5'd0;
      5'd2:    r = 5'd1;
      5'd4:    r = 5'd2;
      5'd7:    r = 5'd3;
      5'd8:    r = 5'd5;
      5'd16:   r = 5'd6;
      5'd17:   r = 5'd7;
      5'd19:   r = 5'd9;
      5'd20:   r = 5'd10;
      5'd21:   r = 5'd11;
      5'd22:   r = 5'd12;
      5'd23:   r = 5'd13;
      5'd24:   r = 5'd14;
      5'd25:   r = 5'd16;
      5'd26:   r = 5'd17;
      5'd27:   r = 5'd18;
      default: r = IDX_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] consonant_jamo(input idx_t i);
    logic [15:0] r;
    case (i)
      5'd0:    r = 16'h3131;
      5'd1:    r = 16'h3132;
      5'd2:    r = 16'h3134;
      5'd3:    r = 16'h3137;
      5'd4:    r = 16'h3138;
      5'd5:    r = 16'h3139;
      5'd6:    r = 16'h3141;
      5'd7:    r = 16'h3142;
      5'd8:    r = 16'h3143;
      5'd9:    r = 16'h3145;
      5'd10:   r = 16'h3146;
      5'd11:   r = 16'h3147;
      5'd12:   r = 16'h3148;
      5'd13:   r = 16'h3149;
      5'd14:   r = 16'h314A;
      5'd15:   r = 16'h314B;
      5'd16:   r = 16'h314C;
      5'd17:   r = 16'h314D;
      5'd18:   r = 16'h314E;
      default: r = CONSONANT_JAMO_BASE;
    endcase
    return r;
  endfunction

  idx_t        init_q, init_d, med_q, med_d, fin_q, fin_d;
  idx_t        ni, nm, nf, cf, f_eff, cmed, cfin;
  logic        has_i, has_m, has_f, has_i_c, has_m_c;
  logic        commit_req, commit_valid, emit_key, erase, tail_valid, second_res;
  logic [15:0] commit_cp;
  logic        sub_q, sub_d;
  logic        can_load, load;
  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d, last_q, last_d;
  logic [15:0] cp_q, cp_d;

  assign has_i = (init_q != IDX_NONE);
  assign has_m = (med_q != IDX_NONE);
  assign has_f = (fin_q != IDX_NONE);
  assign cmed  = combine_medial(med_q, q_item_i.im);
  assign cfin  = combine_final(fin_q, q_item_i.jf);

  always_comb begin
    ni         = init_q;
    nm         = med_q;
    nf         = fin_q;
    cf         = fin_q;
    commit_req = 1'b0;
    emit_key   = 1'b0;
    erase      = 1'b0;
    case (q_item_i.op)
      OP_TYPE: begin
        if (q_item_i.ic == IDX_NONE && q_item_i.im == IDX_NONE) begin
          commit_req = 1'b1;
          emit_key   = 1'b1;
          ni         = IDX_NONE;
          nm         = IDX_NONE;
          nf         = IDX_NONE;
        end else if (!has_i && !has_m) begin
          if (q_item_i.ic != IDX_NONE) ni = q_item_i.ic;
          else nm = q_item_i.im;
        end else if (!has_i || (has_m && !has_f && q_item_i.jf == IDX_NONE)) begin
          if (q_item_i.im != IDX_NONE) begin
            if (cmed != IDX_NONE) begin
              nm = cmed;
            end else begin
              commit_req = 1'b1;
              ni         = IDX_NONE;
              nm         = q_item_i.im;
              nf         = IDX_NONE;
            end
          end else begin
            commit_req = 1'b1;
            ni         = q_item_i.ic;
            nm         = IDX_NONE;
            nf         = IDX_NONE;
          end
        end else if (!has_m) begin
          if (q_item_i.im != IDX_NONE) begin
            nm = q_item_i.im;
          end else begin
            commit_req = 1'b1;
            ni         = q_item_i.ic;
            nm         = IDX_NONE;
            nf         = IDX_NONE;
          end
        end else if (!has_f) begin
          nf = q_item_i.jf;
        end else if (q_item_i.im != IDX_NONE) begin
          cf         = final_keep(fin_q);
          commit_req = 1'b1;
          ni         = final_to_initial(final_moved(fin_q));
          nm         = q_item_i.im;
          nf         = IDX_NONE;
        end else if (q_item_i.jf != IDX_NONE && cfin != IDX_NONE) begin
          nf = cfin;
        end else begin
          commit_req = 1'b1;
          ni         = q_item_i.ic;
          nm         = IDX_NONE;
          nf         = IDX_NONE;
        end
      end
      OP_BACKSPACE: begin
        if (has_f) nf = IDX_NONE;
        else if (has_m) nm = IDX_NONE;
        else if (has_i) ni = IDX_NONE;
        else erase = 1'b1;
      end
      OP_FLUSH: begin
        commit_req = 1'b1;
        ni         = IDX_NONE;
        nm         = IDX_NONE;
        nf         = IDX_NONE;
      end
      default: begin
        commit_req = 1'b0;
      end
    endcase
  end

  assign has_i_c      = (init_q < NUM_INITIALS);
  assign has_m_c      = (med_q < NUM_MEDIALS);
  assign commit_valid = commit_req & (has_i_c | has_m_c);
  assign tail_valid   = emit_key | erase;
  assign second_res   = commit_valid & tail_valid;
  assign f_eff        = (cf <= LAST_FINAL) ? cf : '0;

  always_comb begin
    if (has_i_c && has_m_c) begin
      commit_cp = SYLLABLE_BASE + 16'(init_q) * INITIAL_STRIDE
                + 16'(med_q) * MEDIAL_STRIDE + 16'(f_eff);
    end else if (has_i_c) begin
      commit_cp = consonant_jamo(init_q);
    end else begin
      commit_cp = VOWEL_JAMO_BASE + 16'(med_q);
    end
  end

  assign can_load = !out_valid_q || res_o.ready;

  always_comb begin
    pop_o  = 1'b0;
    load   = 1'b0;
    sub_d  = sub_q;
    init_d = init_q;
    med_d  = med_q;
    fin_d  = fin_q;
    if (q_valid_i) begin
      if (!commit_valid && !tail_valid) begin
        pop_o = 1'b1;
      end else if (can_load) begin
        load = 1'b1;
        if (second_res && !sub_q) begin
          sub_d = 1'b1;
        end else begin
          pop_o = 1'b1;
          sub_d = 1'b0;
        end
      end
    end
    if (pop_o) begin
      init_d = ni;
      med_d  = nm;
      fin_d  = nf;
    end
  end

  always_comb begin
    if (sub_q || !commit_valid) begin
      kind_d = erase ? KIND_ERASE : KIND_CHAR;
      cp_d   = erase ? 16'h0000 : {8'h00, q_item_i.key};
      last_d = 1'b1;
    end else begin
      kind_d = KIND_CHAR;
      cp_d   = commit_cp;
      last_d = !second_res;
    end
  end

  assign out_valid_d = load | (out_valid_q & !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= IDX_NONE;
      med_q       <= IDX_NONE;
      fin_q       <= IDX_NONE;
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      init_q      <= init_d;
      med_q       <= med_d;
      fin_q       <= fin_d;
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      cp_q   <= cp_d;
      last_q <= last_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.kind       = kind_q;
  assign res_o.code_point = cp_q;
  assign res_o.last       = last_q;

endmodule

// File: rtl/hangul_keystroke_composer_core.sv
// Top level of the Hangul keystroke composer.
//
// in_i carries keystroke items: operation (type key, backspace, flush) and
// an ASCII key byte laid out as the two-set Korean keyboard. res_o carries
// result items: kind (committed character or erase), a 16-bit code point
// and last, which marks the final result caused by one keystroke item.
// A keystroke gives zero, one or two results.
//
// The front end classifies each key into initial, medial and final jamo
// indices and writes it into a queue of QueueDepth entries. The back end
// holds the syllable being composed, takes one queued item per cycle when
// the receiver does not stall, and writes results into an output register.
// The first result reaches res_o through the queue and the output register.
// An item with two results holds the back end until both are loaded, as the
// output register takes one result per cycle.
//
// Reset empties the composing syllable, the queue and the output register.
// When the receiver stalls, the output register holds its result, the back
// end waits and the queue fills, after which in_i.ready drops.
module hangul_keystroke_composer_core
  import hkc_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  hkc_in_if.sink   in_i,
  hkc_out_if.source res_o
);

  logic      push, q_ready, q_valid, pop;
  cls_item_t push_item, head_item;

  hkc_front u_front (
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .item_o    (push_item)
  );

  hkc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  hkc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (head_item),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule

// File: rtl/hkc_checker.sv
// Port-level assertions for the Hangul keystroke composer, bound to the top level.
module hkc_checker
  import hkc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic        kind_i,
  input logic [15:0] code_point_i,
  input logic        last_i
);

  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result dropped while stalled");

  a_erase_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_i == KIND_ERASE |-> last_i && code_point_i == 16'h0000)
    else $error("erase result malformed");

  a_first_is_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !last_i |-> kind_i == KIND_CHAR && code_point_i >= CONSONANT_JAMO_BASE)
    else $error("non-final result is not a committed syllable or jamo");

  a_idle_after_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !valid_i)
    else $error("result valid straight after reset");

endmodule

bind hangul_keystroke_composer_core hkc_checker u_hkc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (res_o.valid),
  .ready_i      (res_o.ready),
  .kind_i       (res_o.kind),
  .code_point_i (res_o.code_point),
  .last_i       (res_o.last)
);
